// ----- src/mi3_pkg.sv -----
package mi3_pkg;

  localparam int ENTRY_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_ENT     = 9;
  localparam int DOUT_W      = 64;
  localparam int THR_W       = 63;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(4295);

  localparam int PROD_W  = 2 * ENTRY_WIDTH;
  localparam int ADJ_W   = PROD_W + 1;
  localparam int DET_W   = 3 * ENTRY_WIDTH + 2;
  localparam int NUMER_W = ADJ_W + 2 * FRAC_BITS;
  localparam int REM_W   = (DET_W + ENTRY_WIDTH > NUMER_W) ? DET_W + ENTRY_WIDTH + 1
                                                           : NUMER_W + 1;
  localparam int CMP_W   = DET_W + THR_W + FRAC_BITS + 1;
  localparam int STAGES  = ENTRY_WIDTH + 10;

  localparam int IN_W  = ((NUM_ENT * ENTRY_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((NUM_ENT * ENTRY_WIDTH + DOUT_W + 7) / 8) * 8;

  typedef logic signed [ENTRY_WIDTH-1:0]        ent_t;
  typedef logic [NUM_ENT-1:0][ENTRY_WIDTH-1:0]  ents_t;
  typedef logic signed [PROD_W-1:0]             prod_t;
  typedef logic signed [ADJ_W-1:0]              adj_t;
  typedef logic signed [DET_W-1:0]              det_t;
  typedef logic [DET_W-1:0]                     dmag_t;
  typedef logic [REM_W-1:0]                     rem_t;
  typedef logic [CMP_W-1:0]                     cmp_t;
  typedef logic [ENTRY_WIDTH-1:0]               quo_t;
  typedef logic [ENTRY_WIDTH:0]                 qrnd_t;
  typedef logic signed [DOUT_W-1:0]             dout_t;
  typedef logic [THR_W-1:0]                     thr_t;

  typedef struct packed {
    ents_t              raw;
    dmag_t              dabs;
    dout_t              dval;
    logic               dovf;
    logic               sing;
    logic [NUM_ENT-1:0] qneg;
    logic [NUM_ENT-1:0] satp;
  } side_t;

  // cofactor k = e[A]*e[B] - e[C]*e[D]
  localparam int CF_A [NUM_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CF_B [NUM_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CF_C [NUM_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CF_D [NUM_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  localparam ent_t  ENT_MAX   = ent_t'({1'b0, {(ENTRY_WIDTH-1){1'b1}}});
  localparam ent_t  ENT_MIN   = ent_t'({1'b1, {(ENTRY_WIDTH-1){1'b0}}});
  localparam qrnd_t Q_NEG_LIM = {2'b01, {(ENTRY_WIDTH-1){1'b0}}};
  localparam qrnd_t Q_POS_LIM = Q_NEG_LIM - qrnd_t'(1);
  localparam dout_t DOUT_MAX  = dout_t'({1'b0, {(DOUT_W-1){1'b1}}});
  localparam dout_t DOUT_MIN  = dout_t'({1'b1, {(DOUT_W-1){1'b0}}});
  localparam cmp_t  D_POS_LIM = cmp_t'({1'b0, {(DOUT_W-1){1'b1}}});
  localparam cmp_t  D_NEG_LIM = cmp_t'({1'b1, {(DOUT_W-1){1'b0}}});

endpackage

// ----- src/matrix3x3_inverse.sv -----
// 3x3 matrix inverse by adjugate, Q16.16 in and out, determinant in Q32.32.
// One matrix enters per clock while the pipeline is not frozen; a restoring
// divider produces one quotient bit per stage, nine lanes sharing one divisor.
// A low m_tready with a full output register freezes the whole pipeline, so
// s_tready follows m_tready or an empty output register.
// Singular matrices (|det| <= singular_threshold) come back unchanged with
// the singular flag; overflow flags any saturated entry or determinant.
module matrix3x3_inverse (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mi3_pkg::THR_W-1:0]       cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mi3_pkg::IN_W-1:0]        s_tdata,   // a00,a01,..,a22
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mi3_pkg::OUT_W-1:0]       m_tdata,   // r00,r01,..,r22,determinant
  output logic [1:0]                      m_tuser    // singular, overflow
);

  localparam int EW = mi3_pkg::ENTRY_WIDTH;
  localparam int NE = mi3_pkg::NUM_ENT;

  logic                         en;
  logic [mi3_pkg::STAGES-1:0]   vld;
  mi3_pkg::thr_t                thr;

  mi3_pkg::ents_t  a0, a1, a2, a3, a4, a5, a6;
  mi3_pkg::prod_t  p1 [NE];
  mi3_pkg::prod_t  n1 [NE];
  mi3_pkg::adj_t   adj2 [NE];
  mi3_pkg::adj_t   adj3 [NE];
  mi3_pkg::adj_t   adj4 [NE];
  mi3_pkg::adj_t   adj5 [NE];
  mi3_pkg::adj_t   plo3 [3];
  mi3_pkg::adj_t   phi3 [3];
  mi3_pkg::det_t   t4 [3];
  mi3_pkg::det_t   det5;
  mi3_pkg::dmag_t  dabs6;
  logic            dneg6;
  mi3_pkg::rem_t   num6 [NE];
  logic [NE-1:0]   qneg6;

  mi3_pkg::cmp_t   rd7;
  mi3_pkg::dout_t  dval7;
  logic            dovf7;
  logic            sing7;
  logic [NE-1:0]   satp7;

  mi3_pkg::rem_t   drem [0:EW][NE];
  mi3_pkg::quo_t   dquo [0:EW][NE];
  mi3_pkg::side_t  dside [0:EW];

  mi3_pkg::qrnd_t  rq [NE];
  mi3_pkg::side_t  rside;

  mi3_pkg::ent_t   val [NE];
  logic [NE-1:0]   ovv;

  mi3_pkg::ents_t  out_r;
  mi3_pkg::dout_t  out_det;
  logic            out_sing;
  logic            out_ovf;

  assign en       = !vld[mi3_pkg::STAGES-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[mi3_pkg::STAGES-1];

  always_comb begin
    m_tdata = '0;
    m_tdata[NE*EW-1:0] = out_r;
    m_tdata[NE*EW +: mi3_pkg::DOUT_W] = out_det;
    m_tuser = {out_ovf, out_sing};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= mi3_pkg::THR_RESET;
      vld <= '0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (en) begin
        vld <= {vld[mi3_pkg::STAGES-2:0], s_tvalid};
      end
    end
  end

  // products, cofactors, determinant
  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= s_tdata[NE*EW-1:0];
      a1 <= a0;
      a2 <= a1;
      a3 <= a2;
      a4 <= a3;
      a5 <= a4;
      a6 <= a5;
      for (int j = 0; j < NE; j++) begin
        p1[j] <= mi3_pkg::prod_t'($signed(a0[mi3_pkg::CF_A[j]]))
               * mi3_pkg::prod_t'($signed(a0[mi3_pkg::CF_B[j]]));
        n1[j] <= mi3_pkg::prod_t'($signed(a0[mi3_pkg::CF_C[j]]))
               * mi3_pkg::prod_t'($signed(a0[mi3_pkg::CF_D[j]]));
        adj2[j] <= mi3_pkg::adj_t'(p1[j]) - mi3_pkg::adj_t'(n1[j]);
        adj3[j] <= adj2[j];
        adj4[j] <= adj3[j];
        adj5[j] <= adj4[j];
      end
      for (int k = 0; k < 3; k++) begin
        plo3[k] <= mi3_pkg::adj_t'($signed(a2[k]))
                 * mi3_pkg::adj_t'($signed({1'b0, adj2[3*k][EW-1:0]}));
        phi3[k] <= mi3_pkg::adj_t'($signed(a2[k]))
                 * mi3_pkg::adj_t'($signed(adj2[3*k][mi3_pkg::ADJ_W-1:EW]));
        t4[k] <= (mi3_pkg::det_t'(phi3[k]) <<< EW) + mi3_pkg::det_t'(plo3[k]);
      end
      det5 <= t4[0] + t4[1] + t4[2];
      dneg6 <= det5[mi3_pkg::DET_W-1];
      dabs6 <= det5[mi3_pkg::DET_W-1] ? mi3_pkg::dmag_t'(-det5) : mi3_pkg::dmag_t'(det5);
      for (int j = 0; j < NE; j++) begin
        num6[j] <= (adj5[j][mi3_pkg::ADJ_W-1] ? mi3_pkg::rem_t'(-adj5[j])
                                              : mi3_pkg::rem_t'(adj5[j]))
                   << (2 * mi3_pkg::FRAC_BITS);
        qneg6[j] <= adj5[j][mi3_pkg::ADJ_W-1] ^ det5[mi3_pkg::DET_W-1];
      end
    end
  end

  // determinant rounding, singular test, quotient range check
  always_comb begin
    rd7 = (mi3_pkg::cmp_t'(dabs6) + (mi3_pkg::cmp_t'(1) << (mi3_pkg::FRAC_BITS - 1)))
          >> mi3_pkg::FRAC_BITS;
    if (dneg6) begin
      dovf7 = rd7 > mi3_pkg::D_NEG_LIM;
      dval7 = dovf7 ? mi3_pkg::DOUT_MIN : mi3_pkg::dout_t'(mi3_pkg::cmp_t'(0) - rd7);
    end else begin
      dovf7 = rd7 > mi3_pkg::D_POS_LIM;
      dval7 = dovf7 ? mi3_pkg::DOUT_MAX : mi3_pkg::dout_t'(rd7);
    end
    sing7 = mi3_pkg::cmp_t'(dabs6) <= (mi3_pkg::cmp_t'(thr) << mi3_pkg::FRAC_BITS);
    for (int j = 0; j < NE; j++) begin
      satp7[j] = num6[j] >= (mi3_pkg::rem_t'(dabs6) << EW);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NE; j++) begin
        drem[0][j] <= num6[j];
        dquo[0][j] <= '0;
      end
      dside[0].raw  <= a6;
      dside[0].dabs <= dabs6;
      dside[0].dval <= dval7;
      dside[0].dovf <= dovf7;
      dside[0].sing <= sing7;
      dside[0].qneg <= qneg6;
      dside[0].satp <= satp7;
    end
  end

  // restoring divider, quotient bit EW-1-k in stage k
  for (genvar k = 0; k < EW; k++) begin : g_div
    mi3_pkg::rem_t dv;
    assign dv = mi3_pkg::rem_t'(dside[k].dabs) << (EW - 1 - k);

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < NE; j++) begin
          if (drem[k][j] >= dv) begin
            drem[k+1][j] <= drem[k][j] - dv;
            dquo[k+1][j] <= dquo[k][j] | (mi3_pkg::quo_t'(1) << (EW - 1 - k));
          end else begin
            drem[k+1][j] <= drem[k][j];
            dquo[k+1][j] <= dquo[k][j];
          end
        end
        dside[k+1] <= dside[k];
      end
    end
  end

  // round half away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NE; j++) begin
        rq[j] <= mi3_pkg::qrnd_t'(dquo[EW][j])
               + mi3_pkg::qrnd_t'((drem[EW][j] << 1) >= mi3_pkg::rem_t'(dside[EW].dabs));
      end
      rside <= dside[EW];
    end
  end

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      if (rside.qneg[j]) begin
        ovv[j] = rside.satp[j] || (rq[j] > mi3_pkg::Q_NEG_LIM);
        val[j] = ovv[j] ? mi3_pkg::ENT_MIN
                        : mi3_pkg::ent_t'(mi3_pkg::qrnd_t'(0) - rq[j]);
      end else begin
        ovv[j] = rside.satp[j] || (rq[j] > mi3_pkg::Q_POS_LIM);
        val[j] = ovv[j] ? mi3_pkg::ENT_MAX : mi3_pkg::ent_t'(rq[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NE; j++) begin
        out_r[j] <= rside.sing ? rside.raw[j] : val[j];
      end
      out_det  <= rside.dval;
      out_sing <= rside.sing;
      out_ovf  <= rside.dovf || (!rside.sing && (|ovv));
    end
  end

endmodule

// ----- test/tb_top.sv -----
module tb_top;

  typedef logic signed [255:0] wide_t;
  typedef struct {
    logic [mi3_pkg::OUT_W-1:0] data;
    logic [1:0]                user;
  } inv_word_t;

  class inv_scoreboard;
    inv_word_t      pending_q[$];
    mi3_pkg::thr_t  thr = mi3_pkg::THR_RESET;
    int             errors = 0;

    function automatic wide_t div_round(wide_t n, wide_t d);
      wide_t an, ad, q, r;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = an / ad;
      r = an % ad;
      if ((r <<< 1) >= ad) q = q + 1;
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic [63:0] clip(input wide_t v, input int w, inout bit ovf);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        ovf = 1;
        return hi[63:0];
      end
      if (v < lo) begin
        ovf = 1;
        return lo[63:0];
      end
      return v[63:0];
    endfunction

    function automatic inv_word_t invert(mi3_pkg::ents_t a);
      wide_t m[mi3_pkg::NUM_ENT], adj[mi3_pkg::NUM_ENT];
      wide_t det, dmag, lim;
      logic [63:0] dq;
      inv_word_t w;
      bit ovf;
      ovf = 0;
      for (int i = 0; i < mi3_pkg::NUM_ENT; i++) m[i] = wide_t'(mi3_pkg::ent_t'(a[i]));
      adj[0] = m[4] * m[8] - m[5] * m[7];
      adj[1] = m[2] * m[7] - m[1] * m[8];
      adj[2] = m[1] * m[5] - m[2] * m[4];
      adj[3] = m[5] * m[6] - m[3] * m[8];
      adj[4] = m[0] * m[8] - m[2] * m[6];
      adj[5] = m[2] * m[3] - m[0] * m[5];
      adj[6] = m[3] * m[7] - m[4] * m[6];
      adj[7] = m[1] * m[6] - m[0] * m[7];
      adj[8] = m[0] * m[4] - m[1] * m[3];
      det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
      dq = clip(div_round(det, wide_t'(1) <<< mi3_pkg::FRAC_BITS), 64, ovf);
      dmag = (det < 0) ? -det : det;
      lim = wide_t'({1'b0, thr}) <<< mi3_pkg::FRAC_BITS;
      w.data = '0;
      if (dmag <= lim) begin
        w.data[mi3_pkg::IN_W-1:0] = a;
        w.user[0] = 1'b1;
      end else begin
        for (int i = 0; i < mi3_pkg::NUM_ENT; i++)
          w.data[i*mi3_pkg::ENTRY_WIDTH +: mi3_pkg::ENTRY_WIDTH] =
            mi3_pkg::ent_t'(clip(div_round(adj[i] <<< (2 * mi3_pkg::FRAC_BITS), det),
                                 mi3_pkg::ENTRY_WIDTH, ovf));
        w.user[0] = 1'b0;
      end
      w.data[mi3_pkg::NUM_ENT*mi3_pkg::ENTRY_WIDTH +: 64] = dq;
      w.user[1] = ovf;
      return w;
    endfunction

    function void note(logic [mi3_pkg::IN_W-1:0] din);
      pending_q.push_back(invert(mi3_pkg::ents_t'(din)));
    endfunction

    function void check(logic [mi3_pkg::OUT_W-1:0] data, logic [1:0] user);
      inv_word_t e;
      logic [mi3_pkg::ENTRY_WIDTH-1:0] ev, av;
      if (pending_q.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      for (int i = 0; i < mi3_pkg::NUM_ENT; i++) begin
        ev = e.data[i*mi3_pkg::ENTRY_WIDTH +: mi3_pkg::ENTRY_WIDTH];
        av = data[i*mi3_pkg::ENTRY_WIDTH +: mi3_pkg::ENTRY_WIDTH];
        if (ev !== av) begin
          $error("r%0d%0d: expected %h, got %h", i / 3, i % 3, ev, av);
          errors++;
        end
      end
      if (e.data[mi3_pkg::NUM_ENT*mi3_pkg::ENTRY_WIDTH +: 64] !==
          data[mi3_pkg::NUM_ENT*mi3_pkg::ENTRY_WIDTH +: 64]) begin
        $error("determinant: expected %h, got %h",
               e.data[mi3_pkg::NUM_ENT*mi3_pkg::ENTRY_WIDTH +: 64],
               data[mi3_pkg::NUM_ENT*mi3_pkg::ENTRY_WIDTH +: 64]);
        errors++;
      end
      if (e.user[0] !== user[0]) begin
        $error("singular: expected %b, got %b", e.user[0], user[0]);
        errors++;
      end
      if (e.user[1] !== user[1]) begin
        $error("overflow: expected %b, got %b", e.user[1], user[1]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [mi3_pkg::THR_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [mi3_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [mi3_pkg::OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  inv_scoreboard sb = new();
  bit no_idle = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  matrix3x3_inverse uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= no_idle || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note(s_tdata);
      if (m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= 5000) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic send(mi3_pkg::ents_t m);
    while (!no_idle && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= m;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (mi3_pkg::STAGES + 8) @(posedge clk);
  endtask

  task automatic set_threshold(mi3_pkg::thr_t v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.thr = v;
  endtask

  function automatic mi3_pkg::ent_t rand_ent(int kind);
    unique case (kind)
      0: return mi3_pkg::ent_t'($urandom);
      1: return mi3_pkg::ent_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return mi3_pkg::ent_t'(($signed($urandom_range(0, 8)) - 4) <<< mi3_pkg::FRAC_BITS);
      default: return mi3_pkg::ent_t'($signed($urandom_range(0, 14)) - 7);
    endcase
  endfunction

  function automatic mi3_pkg::ents_t rand_matrix();
    mi3_pkg::ents_t m;
    int kind, sel;
    sel = $urandom_range(9);
    kind = (sel < 3) ? 0 : (sel < 6) ? 1 : (sel < 8) ? 2 : $urandom_range(3);
    if (sel == 9) kind = 3;
    for (int i = 0; i < mi3_pkg::NUM_ENT; i++) m[i] = rand_ent(kind);
    if (sel == 8) begin
      for (int j = 0; j < 3; j++) m[6 + j] = m[$urandom_range(1) * 3 + j];
    end
    return m;
  endfunction

  function automatic mi3_pkg::ents_t diag(mi3_pkg::ent_t x, mi3_pkg::ent_t y,
                                          mi3_pkg::ent_t z);
    mi3_pkg::ents_t m;
    m = '0;
    m[0] = x;
    m[4] = y;
    m[8] = z;
    return m;
  endfunction

  initial begin
    mi3_pkg::ents_t m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(diag(32'h10000, 32'h10000, 32'h10000));
    send(diag(-32'sh10000, -32'sh10000, -32'sh10000));
    send('0);
    m = '0;
    for (int i = 0; i < mi3_pkg::NUM_ENT; i++) m[i] = mi3_pkg::ENT_MAX;
    send(m);
    for (int i = 0; i < mi3_pkg::NUM_ENT; i++) m[i] = mi3_pkg::ENT_MIN;
    send(m);
    send(diag(1, 1, 1));
    send(diag(32'h1000, 32'h1000, 32'h1000));
    send(diag(1, 32'h1000000, 32'h1000000));
    send(diag(-1, 32'h1000000, -32'sh1000000));
    send(diag(mi3_pkg::ENT_MAX, mi3_pkg::ENT_MIN, mi3_pkg::ENT_MAX));
    m = '{mi3_pkg::ENT_MAX, 0, mi3_pkg::ENT_MIN,
          mi3_pkg::ENT_MIN, mi3_pkg::ENT_MAX, 0,
          0, mi3_pkg::ENT_MIN, mi3_pkg::ENT_MAX};
    send(m);
    m = '{0, 0, 32'h10000, 0, 32'h10000, 0, 32'h10000, 0, 0};
    send(m);
    m = '{32'h3, 32'h5, 32'h7, 32'h2, 32'h4, 32'h6, 32'h3, 32'h5, 32'h7};
    send(m);
    m = '{32'h20000, 32'h10000, 0, 32'h10000, 32'h20000, 32'h10000, 0, 32'h10000,
          32'h20000};
    send(m);
    for (int i = 0; i < 6; i++) send(rand_matrix());

    for (int i = 0; i < 150; i++) begin
      no_idle = (i >= 60 && i < 100);
      send(rand_matrix());
    end
    no_idle = 0;

    set_threshold('0);
    for (int i = 0; i < 100; i++) send(rand_matrix());
    set_threshold({mi3_pkg::THR_W{1'b1}});
    for (int i = 0; i < 50; i++) send(rand_matrix());
    set_threshold(mi3_pkg::thr_t'({$urandom, $urandom}) >> $urandom_range(0, 40));
    for (int i = 0; i < 130; i++) send(rand_matrix());

    drain();
    if (sb.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
